// File: src/mf3_pkg.sv
// Package: shared types and constants of the 3x3 median filter.
`default_nettype none
package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROW_W      = 10;
  localparam int HEIGHT_CAP = 1024;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [ROW_W-1:0]      row_t;

  localparam cfg_idx_t  REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t  REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_data_t WIDTH_RESET      = 11'd512;
  localparam cfg_data_t HEIGHT_RESET     = 11'd512;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } trio_t;

endpackage
`default_nettype wire

// File: src/mf3_if.sv
// Interfaces: pixel input, median result and configuration write channels.
`default_nettype none
interface mf3_pix_if;
  logic          valid;
  logic          ready;
  mf3_pkg::pix_t pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface mf3_med_if;
  logic          valid;
  logic          ready;
  mf3_pkg::pix_t median_out;
  logic          frame_last;
  modport source (output valid, output median_out, output frame_last, input ready);
  modport sink   (input valid, input median_out, input frame_last, output ready);
endinterface

interface mf3_cfg_if;
  logic               valid;
  logic               ready;
  mf3_pkg::cfg_idx_t  index;
  mf3_pkg::cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: src/median_filter_3x3.sv
// Top level: streaming 3x3 median filter with a two-row line memory.
// An accepted pixel passes stages 1, 2 and 3, then the output register.
// Throughput: one pixel per cycle; one line-memory read and one write per cycle.
// Stalls only while the output register holds a word not taken.
// Reset (synchronous, rst_n low): pipeline empty, counters zero, window zero,
// width/height back to 512; line memory contents are left as they are.
`default_nettype none
module median_filter_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire        clk,
  input  wire        rst_n,
  mf3_pix_if.sink    in_pix,
  mf3_med_if.source  out_med,
  mf3_cfg_if.sink    cfg_wr
);
  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  typedef logic [CW-1:0] col_t;

  function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t x, y, z, t;
    trio_t s;
    x = a; y = b; z = c;
    if (x > y) begin t = x; x = y; y = t; end
    if (y > z) begin t = y; y = z; z = t; end
    if (x > y) begin t = x; x = y; y = t; end
    s.lo = x; s.mid = y; s.hi = z;
    return s;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    trio_t s;
    s = sort3(a, b, c);
    return s.mid;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // configuration
  cfg_data_t cfg_width_r, cfg_height_r;
  col_t      w_last;
  row_t      h_last;
  logic      cfg_fire;

  assign cfg_wr.ready = 1'b1;
  assign cfg_fire = cfg_wr.valid && cfg_wr.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
    end else if (cfg_fire) begin
      if (cfg_wr.index == REG_IMAGE_WIDTH)  cfg_width_r  <= cfg_wr.data;
      if (cfg_wr.index == REG_IMAGE_HEIGHT) cfg_height_r <= cfg_wr.data;
    end
  end

  always_comb begin
    if (cfg_width_r < 11'd3)                w_last = CW'(2);
    else if (int'(cfg_width_r) > MAX_WIDTH) w_last = CW'(MAX_WIDTH - 1);
    else                                    w_last = CW'(cfg_width_r - 11'd1);
    if (cfg_height_r < 11'd3)                 h_last = ROW_W'(2);
    else if (int'(cfg_height_r) > HEIGHT_CAP) h_last = ROW_W'(HEIGHT_CAP - 1);
    else                                      h_last = ROW_W'(cfg_height_r - 11'd1);
  end

  // pipeline control
  logic adv, in_fire;
  logic out_valid_r;

  assign adv          = !out_valid_r || out_med.ready;
  assign in_pix.ready = adv;
  assign in_fire      = in_pix.valid && adv;

  // position counters
  col_t col_r;
  row_t row_r;
  logic cfg_idx_ok;

  assign cfg_idx_ok = (cfg_wr.index == REG_IMAGE_WIDTH) || (cfg_wr.index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_fire && cfg_idx_ok) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (col_r == w_last) begin
        col_r <= '0;
        row_r <= (row_r == h_last) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // line memory: [15:8] row r-2, [7:0] row r-1
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_r;
  logic [2*PIX_W-1:0] wr_word;

  // stage 1: pixel with its line memory read
  logic v1_r, emit1_r, last1_r;
  pix_t px1_r;
  col_t idx1_r;
  pix_t top1, mid1;
  logic wr_en;

  assign top1    = rd_r[2*PIX_W-1:PIX_W];
  assign mid1    = rd_r[PIX_W-1:0];
  assign wr_word = {mid1, px1_r};
  assign wr_en   = v1_r && adv;

  always_ff @(posedge clk) begin
    if (wr_en) line_mem[idx1_r] <= wr_word;
    if (in_fire) begin
      if (wr_en && idx1_r == col_r) rd_r <= wr_word;
      else                          rd_r <= line_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px1_r   <= in_pix.pixel_in;
      idx1_r  <= col_r;
      emit1_r <= (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
      last1_r <= (row_r == h_last) && (col_r == w_last);
    end
  end

  // window columns c-2 and c-1
  pix_t win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (wr_en) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top1;
      win_r[4] <= mid1;
      win_r[5] <= px1_r;
    end
  end

  // stage 2: each row sorted
  logic  v2_r, last2_r;
  trio_t row0_r, row1_r, row2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r && emit1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row0_r  <= sort3(win_r[0], win_r[3], top1);
      row1_r  <= sort3(win_r[1], win_r[4], mid1);
      row2_r  <= sort3(win_r[2], win_r[5], px1_r);
      last2_r <= last1_r;
    end
  end

  // stage 3: max of lows, median of mids, min of highs
  logic  v3_r, last3_r;
  trio_t cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2_r) begin
      cand_r.lo  <= max3(row0_r.lo, row1_r.lo, row2_r.lo);
      cand_r.mid <= med3(row0_r.mid, row1_r.mid, row2_r.mid);
      cand_r.hi  <= min3(row0_r.hi, row1_r.hi, row2_r.hi);
      last3_r    <= last2_r;
    end
  end

  // output register
  pix_t median_r;
  logic frame_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v3_r) begin
      median_r     <= med3(cand_r.lo, cand_r.mid, cand_r.hi);
      frame_last_r <= last3_r;
    end
  end

  assign out_med.valid      = out_valid_r;
  assign out_med.median_out = median_r;
  assign out_med.frame_last = frame_last_r;

endmodule
`default_nettype wire
